### rtl/fnu_pkg.sv
// ----------------------------------------------------------------------------
// fnu_pkg
// Shared constants for the face normal unit.
// ----------------------------------------------------------------------------
package fnu_pkg;

  localparam int UNIT_BITS = 16;

endpackage

### rtl/fnu_if.sv
// ----------------------------------------------------------------------------
// fnu_if
// Valid/ready channels: triangle vertices in, unit normal out.
// ----------------------------------------------------------------------------
interface fnu_in_if #(parameter int COORD_BITS = 10);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] first_x;
  logic signed [COORD_BITS-1:0] first_y;
  logic signed [COORD_BITS-1:0] first_z;
  logic signed [COORD_BITS-1:0] second_x;
  logic signed [COORD_BITS-1:0] second_y;
  logic signed [COORD_BITS-1:0] second_z;
  logic signed [COORD_BITS-1:0] third_x;
  logic signed [COORD_BITS-1:0] third_y;
  logic signed [COORD_BITS-1:0] third_z;

  modport source (output valid, first_x, first_y, first_z, second_x, second_y,
                  second_z, third_x, third_y, third_z, input ready);
  modport sink   (input valid, first_x, first_y, first_z, second_x, second_y,
                  second_z, third_x, third_y, third_z, output ready);
endinterface

interface fnu_out_if import fnu_pkg::*; ;
  logic                        valid;
  logic                        ready;
  logic signed [UNIT_BITS-1:0] unit_x;
  logic signed [UNIT_BITS-1:0] unit_y;
  logic signed [UNIT_BITS-1:0] unit_z;
  logic                        degenerate;

  modport source (output valid, unit_x, unit_y, unit_z, degenerate, input ready);
  modport sink   (input valid, unit_x, unit_y, unit_z, degenerate, output ready);
endinterface

### rtl/fnu_lane.sv
// ----------------------------------------------------------------------------
// fnu_lane
// Pipelined quotient c * 2^F / sqrt(L), one result bit per stage, by
// restoring search on residual c^2*2^2F - q^2*L with a running q*L.
// ----------------------------------------------------------------------------
module fnu_lane #(
  parameter int FRAC_BITS = 14,
  parameter int C2W       = 44,
  parameter int LW        = 46
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [C2W-1:0]       c2,
  input  logic [LW-1:0]        len2,
  output logic [FRAC_BITS:0]   q
);

  localparam int W  = LW + 2*FRAC_BITS + 3;
  localparam int QW = FRAC_BITS + 1;

  logic [W-1:0]  st_r  [0:FRAC_BITS];
  logic [W-1:0]  st_ql [0:FRAC_BITS];
  logic [LW-1:0] st_l  [0:FRAC_BITS];
  logic [QW-1:0] st_q  [0:FRAC_BITS];

  for (genvar j = 0; j <= FRAC_BITS; j++) begin : g_bit
    localparam int B = FRAC_BITS - j;
    logic [W-1:0]  pr, pql, d, lw;
    logic [LW-1:0] pl;
    logic [QW-1:0] pq;
    logic          take;

    if (j == 0) begin : g_head
      assign pr  = W'(c2) << (2*FRAC_BITS);
      assign pql = '0;
      assign pl  = len2;
      assign pq  = '0;
    end else begin : g_body
      assign pr  = st_r[j-1];
      assign pql = st_ql[j-1];
      assign pl  = st_l[j-1];
      assign pq  = st_q[j-1];
    end

    assign lw   = W'(pl);
    assign d    = (pql << (B+1)) + (lw << (2*B));
    assign take = (d <= pr);

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[j]  <= take ? pr - d : pr;
        st_ql[j] <= take ? pql + (lw << B) : pql;
        st_l[j]  <= pl;
        st_q[j]  <= take ? (pq | (QW'(1) << B)) : pq;
      end
    end
  end

  assign q = st_q[FRAC_BITS];

endmodule

### rtl/face_normal_unit.sv
// ----------------------------------------------------------------------------
// face_normal_unit
// Unit face normal of a triangle: cross product of (third - second) and
// (first - second), scaled to length 2^FRAC_BITS, truncated toward zero.
//
//   channel   dir  fields
//   vertices  in   first_*, second_*, third_* (x, y, z)
//   normal    out  unit_x, unit_y, unit_z, degenerate
//
// One transfer per cycle in and out while the output is not stalled. Six
// front stages (differences, products, cross, magnitudes, squares, length)
// then FRAC_BITS + 1 quotient bit stages and the output register.
// Synchronous reset clears the valid pipeline only.
// A stalled output freezes the whole pipeline; vertices.ready falls with it.
// ----------------------------------------------------------------------------
module face_normal_unit import fnu_pkg::*; #(
  parameter int COORD_BITS = 10,
  parameter int FRAC_BITS  = 14
) (
  input  logic       clk,
  input  logic       rst,
  fnu_in_if.sink     vertices,
  fnu_out_if.source  normal
);

  localparam int CB  = COORD_BITS;
  localparam int DW  = CB + 1;
  localparam int PW  = 2*DW;
  localparam int NW  = PW + 1;
  localparam int MW  = PW;
  localparam int C2W = 2*MW;
  localparam int LW  = C2W + 2;
  localparam int QW  = FRAC_BITS + 1;
  localparam int VN  = FRAC_BITS + 7;

  logic en;
  logic vld [0:VN-1];

  logic signed [DW-1:0] ax, ay, az, bx, by, bz;
  logic signed [PW-1:0] p_aybz, p_azby, p_azbx, p_axbz, p_axby, p_aybx;
  logic signed [NW-1:0] nx, ny, nz;
  logic [MW-1:0]  mx, my, mz;
  logic [C2W-1:0] c2x, c2y, c2z, c2x5, c2y5, c2z5;
  logic [2:0]     sgn4, sgn5;
  logic [LW-1:0]  len2;
  logic [2:0]     sgn_d [0:FRAC_BITS+1];
  logic           deg_d [0:FRAC_BITS+1];
  logic [QW-1:0]  qx, qy, qz;

  assign en             = !normal.valid || normal.ready;
  assign vertices.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < VN; i++) vld[i] <= 1'b0;
      normal.valid <= 1'b0;
    end else if (en) begin
      vld[0] <= vertices.valid;
      for (int i = 1; i < VN; i++) vld[i] <= vld[i-1];
      normal.valid <= vld[VN-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax <= {vertices.third_x[CB-1], vertices.third_x}
          - {vertices.second_x[CB-1], vertices.second_x};
      ay <= {vertices.third_y[CB-1], vertices.third_y}
          - {vertices.second_y[CB-1], vertices.second_y};
      az <= {vertices.third_z[CB-1], vertices.third_z}
          - {vertices.second_z[CB-1], vertices.second_z};
      bx <= {vertices.first_x[CB-1], vertices.first_x}
          - {vertices.second_x[CB-1], vertices.second_x};
      by <= {vertices.first_y[CB-1], vertices.first_y}
          - {vertices.second_y[CB-1], vertices.second_y};
      bz <= {vertices.first_z[CB-1], vertices.first_z}
          - {vertices.second_z[CB-1], vertices.second_z};

      p_aybz <= ay * bz;
      p_azby <= az * by;
      p_azbx <= az * bx;
      p_axbz <= ax * bz;
      p_axby <= ax * by;
      p_aybx <= ay * bx;

      nx <= {p_aybz[PW-1], p_aybz} - {p_azby[PW-1], p_azby};
      ny <= {p_azbx[PW-1], p_azbx} - {p_axbz[PW-1], p_axbz};
      nz <= {p_axby[PW-1], p_axby} - {p_aybx[PW-1], p_aybx};

      mx   <= nx[NW-1] ? MW'(-nx) : MW'(nx);
      my   <= ny[NW-1] ? MW'(-ny) : MW'(ny);
      mz   <= nz[NW-1] ? MW'(-nz) : MW'(nz);
      sgn4 <= {nz[NW-1], ny[NW-1], nx[NW-1]};

      c2x   <= mx * mx;
      c2y   <= my * my;
      c2z   <= mz * mz;
      sgn5  <= sgn4;

      c2x5   <= c2x;
      c2y5   <= c2y;
      c2z5   <= c2z;
      len2   <= LW'(c2x) + LW'(c2y) + LW'(c2z);
      sgn_d[0] <= sgn5;
      deg_d[0] <= (c2x == '0) && (c2y == '0) && (c2z == '0);
      for (int i = 1; i <= FRAC_BITS + 1; i++) begin
        sgn_d[i] <= sgn_d[i-1];
        deg_d[i] <= deg_d[i-1];
      end
    end
  end

  fnu_lane #(.FRAC_BITS(FRAC_BITS), .C2W(C2W), .LW(LW)) u_lane_x (
    .clk(clk), .en(en), .c2(c2x5), .len2(len2), .q(qx));
  fnu_lane #(.FRAC_BITS(FRAC_BITS), .C2W(C2W), .LW(LW)) u_lane_y (
    .clk(clk), .en(en), .c2(c2y5), .len2(len2), .q(qy));
  fnu_lane #(.FRAC_BITS(FRAC_BITS), .C2W(C2W), .LW(LW)) u_lane_z (
    .clk(clk), .en(en), .c2(c2z5), .len2(len2), .q(qz));

  logic [QW+UNIT_BITS-1:0] wx, wy, wz;
  logic [UNIT_BITS-1:0]    ux, uy, uz;
  logic                    deg_o;

  assign wx    = {{UNIT_BITS{1'b0}}, qx};
  assign wy    = {{UNIT_BITS{1'b0}}, qy};
  assign wz    = {{UNIT_BITS{1'b0}}, qz};
  assign ux    = wx[UNIT_BITS-1:0];
  assign uy    = wy[UNIT_BITS-1:0];
  assign uz    = wz[UNIT_BITS-1:0];
  assign deg_o = deg_d[FRAC_BITS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      normal.degenerate <= deg_o;
      normal.unit_x <= deg_o ? '0 : (sgn_d[FRAC_BITS+1][0] ? ~ux + 1'b1 : ux);
      normal.unit_y <= deg_o ? '0 : (sgn_d[FRAC_BITS+1][1] ? ~uy + 1'b1 : uy);
      normal.unit_z <= deg_o ? '0 : (sgn_d[FRAC_BITS+1][2] ? ~uz + 1'b1 : uz);
    end
  end

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    normal.valid && normal.degenerate |->
      normal.unit_x == '0 && normal.unit_y == '0 && normal.unit_z == '0)
    else $error("degenerate result with non-zero normal");

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    normal.valid && !normal.ready |=> normal.valid && $stable(normal.unit_x)
      && $stable(normal.unit_y) && $stable(normal.unit_z))
    else $error("stalled result changed");

  a_no_take_on_stall: assert property (@(posedge clk) disable iff (rst)
    normal.valid && !normal.ready |-> !vertices.ready)
    else $error("input taken while pipeline frozen");

endmodule
